/* rtl/krfp_pkg.sv */
// Package for the keyed record frame parser.
// Holds the configuration widths, register indexes, character codes, event codes
// and the classified byte word. It has no dependencies.
package krfp_pkg;

    // Fixed widths of the configuration registers and table slots.
    localparam int RC_W      = 4;
    localparam int KEY_W     = 64;
    localparam int HDR_W     = 40;
    localparam int MARK_W    = 8;
    localparam int CFG_DW    = 64;
    localparam int CFG_IW    = 2;
    localparam int KEY_SLOTS = 8;
    localparam int HDR_SLOTS = 5;
    localparam int REC_W     = 3;
    localparam int FLD_W     = 3;
    localparam int KIND_W    = 3;
    localparam int OUT_VW    = 32;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_RECORD_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_KEY_TABLE    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_HEADER_TABLE = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_END_MARKER   = 2'd3;

    // Characters with a special meaning in the stream.
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Event codes reported on the result channel.
    localparam logic [KIND_W-1:0] EV_FIELD   = 3'd0;
    localparam logic [KIND_W-1:0] EV_OK      = 3'd1;
    localparam logic [KIND_W-1:0] EV_NO_T    = 3'd2;
    localparam logic [KIND_W-1:0] EV_ABORT   = 3'd3;
    localparam logic [KIND_W-1:0] EV_REBOOT  = 3'd4;
    localparam logic [KIND_W-1:0] EV_ECHO    = 3'd5;
    localparam logic [KIND_W-1:0] EV_START   = 3'd6;

    // One received byte together with its state-independent classification.
    typedef struct packed {
        logic [7:0]           rx_byte;
        logic [KEY_SLOTS-1:0] key_hit;
        logic [HDR_SLOTS-1:0] hdr_hit;
        logic [HDR_SLOTS-1:0] hdr_end;
        logic                 is_t;
        logic                 is_y;
        logic                 is_z;
        logic                 is_n;
        logic                 is_plus;
        logic                 is_minus;
    } cls_t;

endpackage

/* rtl/krfp_if.sv */
// Channel interfaces of the keyed record frame parser.
// Depends on krfp_pkg for the payload widths.
interface krfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface krfp_evt_if;
    logic                             valid;
    logic                             ready;
    logic [krfp_pkg::KIND_W-1:0]      event_kind;
    logic [krfp_pkg::REC_W-1:0]       record_index;
    logic [krfp_pkg::FLD_W-1:0]       field_index;
    logic signed [krfp_pkg::OUT_VW-1:0] field_value;
    modport source (output valid, output event_kind, output record_index,
                    output field_index, output field_value, input ready);
    modport sink (input valid, input event_kind, input record_index,
                  input field_index, input field_value, output ready);
endinterface

interface krfp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [krfp_pkg::CFG_IW-1:0]   index;
    logic [krfp_pkg::CFG_DW-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/keyed_record_frame_parser_top.sv */
// Top level of the keyed record frame parser.
// Depends on krfp_pkg, krfp_if.sv, krfp_front, krfp_fifo and krfp_back.
//
//   channel  direction  contents
//   rx       in         rx_byte, one character per word
//   evt      out        event_kind, record_index, field_index, field_value
//   cfg      in         index (0..3) and data for one configuration register
//
// One byte per clock is taken while rx.ready is high, and at most one event
// word leaves per clock. A byte passes the classifier register, a two-entry
// queue and the parser register before its event appears. The parser step
// (key priority pick, header search, multiply-by-ten add) handles one queued
// byte each cycle while results are taken; result back-pressure fills the
// queue and then the classifier before rx.ready drops. Reset clears the
// control state at once, not the byte data; there is no clearing pass.
module keyed_record_frame_parser_top
#(
    parameter int MAX_RECORDS = 8,
    parameter int FIELDS      = 5,
    parameter int VALUE_BITS  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    krfp_rx_if.sink     rx,
    krfp_evt_if.source  evt,
    krfp_cfg_if.sink    cfg
);

    logic                      front_valid;
    logic                      front_ready;
    krfp_pkg::cls_t            front_word;
    logic                      queue_valid;
    logic                      queue_ready;
    krfp_pkg::cls_t            queue_word;
    logic [krfp_pkg::RC_W-1:0] record_count;

    // Classifier and configuration registers.
    krfp_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx           (rx),
        .cfg          (cfg),
        .cls_valid    (front_valid),
        .cls_ready    (front_ready),
        .cls_word     (front_word),
        .record_count (record_count)
    );

    // Queue between the classifier and the parser.
    krfp_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_word  (front_word),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_word   (queue_word)
    );

    // Frame parser and event register.
    krfp_back
    #(
        .MAX_RECORDS (MAX_RECORDS),
        .FIELDS      (FIELDS),
        .VALUE_BITS  (VALUE_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cls_valid    (queue_valid),
        .cls_ready    (queue_ready),
        .cls_word     (queue_word),
        .record_count (record_count),
        .evt          (evt)
    );

endmodule

/* rtl/krfp_front.sv */
// Front end: configuration registers and the byte classifier stage.
// Depends on krfp_pkg and the channel interfaces in krfp_if.sv.
module krfp_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    krfp_rx_if.sink                    rx,
    krfp_cfg_if.sink                   cfg,
    output logic                       cls_valid,
    input  logic                       cls_ready,
    output krfp_pkg::cls_t             cls_word,
    output logic [krfp_pkg::RC_W-1:0]  record_count
);

    logic [krfp_pkg::RC_W-1:0]   record_count_reg;
    logic [krfp_pkg::KEY_W-1:0]  key_table_reg;
    logic [krfp_pkg::HDR_W-1:0]  header_table_reg;
    logic [krfp_pkg::MARK_W-1:0] end_marker_reg;
    logic                        cls_valid_reg;
    krfp_pkg::cls_t              cls_reg;
    krfp_pkg::cls_t              cls_next;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_count_reg <= '0;
            key_table_reg    <= '0;
            header_table_reg <= '0;
            end_marker_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                krfp_pkg::CFG_RECORD_COUNT: record_count_reg <= cfg.data[krfp_pkg::RC_W-1:0];
                krfp_pkg::CFG_KEY_TABLE:    key_table_reg    <= cfg.data[krfp_pkg::KEY_W-1:0];
                krfp_pkg::CFG_HEADER_TABLE: header_table_reg <= cfg.data[krfp_pkg::HDR_W-1:0];
                krfp_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg.data[krfp_pkg::MARK_W-1:0];
                default:                    end_marker_reg   <= end_marker_reg;
            endcase
        end
    end

    // Compare the byte against every key and header slot in parallel.
    always_comb
    begin
        cls_next.rx_byte = rx.rx_byte;
        for (int i = 0; i < krfp_pkg::KEY_SLOTS; i++)
        begin
            cls_next.key_hit[i] = (key_table_reg[i*8 +: 8] == rx.rx_byte);
        end
        for (int j = 0; j < krfp_pkg::HDR_SLOTS; j++)
        begin
            cls_next.hdr_hit[j] = (header_table_reg[j*8 +: 8] == rx.rx_byte);
            cls_next.hdr_end[j] = (header_table_reg[j*8 +: 8] == end_marker_reg);
        end
        cls_next.is_t     = (rx.rx_byte == krfp_pkg::CH_T);
        cls_next.is_y     = (rx.rx_byte == krfp_pkg::CH_Y);
        cls_next.is_z     = (rx.rx_byte == krfp_pkg::CH_Z);
        cls_next.is_n     = (rx.rx_byte == krfp_pkg::CH_N);
        cls_next.is_plus  = (rx.rx_byte == krfp_pkg::CH_PLUS);
        cls_next.is_minus = (rx.rx_byte == krfp_pkg::CH_MINUS);
    end

    // Classified word register; refills whenever it empties or moves on.
    assign rx.ready = !cls_valid_reg || cls_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            cls_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid    = cls_valid_reg;
    assign cls_word     = cls_reg;
    assign record_count = record_count_reg;

endmodule

/* rtl/krfp_fifo.sv */
// Two-entry queue of classified words between front end and parser.
// Depends on krfp_pkg for the word type.
module krfp_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  krfp_pkg::cls_t push_word,
    output logic           pop_valid,
    input  logic           pop_ready,
    output krfp_pkg::cls_t pop_word
);

    krfp_pkg::cls_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = slot_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops, both allowed in one cycle.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* rtl/krfp_back.sv */
// Back end: frame state machine, value accumulator and event register.
// Depends on krfp_pkg and the result interface in krfp_if.sv.
module krfp_back
#(
    parameter int MAX_RECORDS = 8,
    parameter int FIELDS      = 5,
    parameter int VALUE_BITS  = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cls_valid,
    output logic                      cls_ready,
    input  krfp_pkg::cls_t            cls_word,
    input  logic [krfp_pkg::RC_W-1:0] record_count,
    krfp_evt_if.source                evt
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_FIRST,
        PH_HEADER,
        PH_VALUE,
        PH_REKEY
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [krfp_pkg::REC_W-1:0]          rec_reg, rec_next;
    logic [krfp_pkg::FLD_W-1:0]          fld_reg, fld_next;
    logic [VALUE_BITS-1:0]               acc_reg, acc_next;
    logic [7:0]                          key_reg, key_next;
    logic                                evt_valid_reg, evt_valid_next;
    logic [krfp_pkg::KIND_W-1:0]         kind_reg, kind_next;
    logic [krfp_pkg::REC_W-1:0]          out_rec_reg, out_rec_next;
    logic [krfp_pkg::FLD_W-1:0]          out_fld_reg, out_fld_next;
    logic signed [krfp_pkg::OUT_VW-1:0]  out_val_reg, out_val_next;

    logic                                take;
    logic [krfp_pkg::RC_W-1:0]           lim;
    logic [MAX_RECORDS-1:0]              key_cand;
    logic                                key_found;
    logic [krfp_pkg::REC_W-1:0]          key_idx;
    logic                                hdr_found;
    logic                                hdr_stop;
    logic [krfp_pkg::FLD_W-1:0]          hdr_idx;
    logic                                hdr_cur_end;
    logic                                hdr_done;
    logic [VALUE_BITS-1:0]               acc_step;
    logic [VALUE_BITS-1:0]               acc_final;

    assign cls_ready = !evt_valid_reg || evt.ready;
    assign take      = cls_valid && cls_ready;

    // Records in use, saturated at the record capacity.
    assign lim = (record_count > krfp_pkg::RC_W'(MAX_RECORDS)) ?
                 krfp_pkg::RC_W'(MAX_RECORDS) : record_count;

    // Lowest matching key in use; past the current record unless in PH_FIRST.
    always_comb
    begin
        key_found = 1'b0;
        key_idx   = '0;
        for (int i = 0; i < MAX_RECORDS; i++)
        begin
            key_cand[i] = cls_word.key_hit[i] && (krfp_pkg::RC_W'(i) < lim) &&
                          ((phase_reg == PH_FIRST) || (krfp_pkg::REC_W'(i) > rec_reg));
        end
        for (int i = MAX_RECORDS - 1; i >= 0; i--)
        begin
            if (key_cand[i])
            begin
                key_found = 1'b1;
                key_idx   = krfp_pkg::REC_W'(i);
            end
        end
    end

    // Header search from the current field up to the end marker.
    always_comb
    begin
        hdr_found   = 1'b0;
        hdr_stop    = 1'b0;
        hdr_idx     = '0;
        hdr_cur_end = 1'b0;
        for (int j = 0; j < FIELDS; j++)
        begin
            if ((krfp_pkg::FLD_W'(j) >= fld_reg) && !hdr_stop && !hdr_found)
            begin
                if (cls_word.hdr_end[j])
                begin
                    hdr_stop = 1'b1;
                end
                else if (cls_word.hdr_hit[j])
                begin
                    hdr_found = 1'b1;
                    hdr_idx   = krfp_pkg::FLD_W'(j);
                end
            end
        end
        // The header slot of the current field, if it is one of the slots.
        for (int j = 0; j < krfp_pkg::HDR_SLOTS; j++)
        begin
            if (fld_reg == krfp_pkg::FLD_W'(j))
            begin
                hdr_cur_end = cls_word.hdr_end[j];
            end
        end
        hdr_done = (fld_reg >= krfp_pkg::FLD_W'(FIELDS)) || hdr_cur_end;
    end

    // Ten times the value plus the byte less the zero character, wrapping.
    assign acc_step  = (acc_reg << 3) + (acc_reg << 1) +
                       VALUE_BITS'(cls_word.rx_byte) - VALUE_BITS'(krfp_pkg::CH_ZERO);
    assign acc_final = cls_word.is_minus ? (VALUE_BITS'(0) - acc_reg) : acc_reg;

    // Next state and event for the word at the head of the queue.
    always_comb
    begin
        phase_next     = phase_reg;
        rec_next       = rec_reg;
        fld_next       = fld_reg;
        acc_next       = acc_reg;
        key_next       = key_reg;
        evt_valid_next = evt_valid_reg && !evt.ready;
        kind_next      = kind_reg;
        out_rec_next   = out_rec_reg;
        out_fld_next   = out_fld_reg;
        out_val_next   = out_val_reg;

        if (take)
        begin
            // Default for any event: status only, no record data.
            out_rec_next = '0;
            out_fld_next = '0;
            out_val_next = '0;

            if (cls_word.is_z)
            begin
                phase_next     = PH_WAIT;
                rec_next       = '0;
                fld_next       = '0;
                acc_next       = '0;
                key_next       = '0;
                evt_valid_next = 1'b1;
                kind_next      = krfp_pkg::EV_REBOOT;
            end
            else if (cls_word.is_n)
            begin
                evt_valid_next = 1'b1;
                kind_next      = krfp_pkg::EV_ECHO;
            end
            else
            begin
                unique case (phase_reg)
                    PH_WAIT:
                    begin
                        phase_next     = PH_FIRST;
                        rec_next       = '0;
                        fld_next       = '0;
                        acc_next       = '0;
                        key_next       = '0;
                        evt_valid_next = 1'b1;
                        kind_next      = krfp_pkg::EV_START;
                    end
                    PH_VALUE:
                    begin
                        if (cls_word.is_y)
                        begin
                            phase_next     = PH_WAIT;
                            rec_next       = '0;
                            fld_next       = '0;
                            acc_next       = '0;
                            key_next       = '0;
                            evt_valid_next = 1'b1;
                            kind_next      = krfp_pkg::EV_ABORT;
                        end
                        else if (cls_word.is_plus || cls_word.is_minus)
                        begin
                            evt_valid_next = 1'b1;
                            kind_next      = krfp_pkg::EV_FIELD;
                            out_rec_next   = rec_reg;
                            out_fld_next   = fld_reg;
                            out_val_next   = krfp_pkg::OUT_VW'($signed(acc_final));
                            fld_next       = fld_reg + 1'b1;
                            acc_next       = '0;
                            phase_next     = PH_REKEY;
                        end
                        else
                        begin
                            acc_next = acc_step;
                        end
                    end
                    PH_FIRST, PH_HEADER, PH_REKEY:
                    begin
                        if (phase_reg == PH_REKEY && cls_word.rx_byte == key_reg)
                        begin
                            phase_next = PH_HEADER;
                        end
                        else if (cls_word.is_y &&
                                 (phase_reg == PH_FIRST ||
                                  (phase_reg == PH_HEADER && !hdr_done)))
                        begin
                            phase_next     = PH_WAIT;
                            rec_next       = '0;
                            fld_next       = '0;
                            acc_next       = '0;
                            key_next       = '0;
                            evt_valid_next = 1'b1;
                            kind_next      = krfp_pkg::EV_ABORT;
                        end
                        else if (phase_reg == PH_HEADER && !hdr_done && hdr_found)
                        begin
                            phase_next = PH_VALUE;
                            fld_next   = hdr_idx;
                            acc_next   = '0;
                        end
                        else if (key_found)
                        begin
                            phase_next = PH_HEADER;
                            rec_next   = key_idx;
                            fld_next   = '0;
                            key_next   = cls_word.rx_byte;
                        end
                        else
                        begin
                            phase_next     = PH_WAIT;
                            rec_next       = '0;
                            fld_next       = '0;
                            acc_next       = '0;
                            key_next       = '0;
                            evt_valid_next = 1'b1;
                            kind_next      = cls_word.is_t ? krfp_pkg::EV_OK :
                                                             krfp_pkg::EV_NO_T;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                        rec_next   = '0;
                        fld_next   = '0;
                        acc_next   = '0;
                        key_next   = '0;
                    end
                endcase
            end
        end
    end

    // State and the registered event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            rec_reg       <= '0;
            fld_reg       <= '0;
            acc_reg       <= '0;
            key_reg       <= '0;
            evt_valid_reg <= 1'b0;
            kind_reg      <= '0;
            out_rec_reg   <= '0;
            out_fld_reg   <= '0;
            out_val_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rec_reg       <= rec_next;
            fld_reg       <= fld_next;
            acc_reg       <= acc_next;
            key_reg       <= key_next;
            evt_valid_reg <= evt_valid_next;
            kind_reg      <= kind_next;
            out_rec_reg   <= out_rec_next;
            out_fld_reg   <= out_fld_next;
            out_val_reg   <= out_val_next;
        end
    end

    assign evt.valid        = evt_valid_reg;
    assign evt.event_kind   = kind_reg;
    assign evt.record_index = out_rec_reg;
    assign evt.field_index  = out_fld_reg;
    assign evt.field_value  = out_val_reg;

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for keyed_record_frame_parser_top.
// Needs krfp_pkg, the channel interfaces in krfp_if.sv and the parser RTL.
// It sends keyed record frames and noise bytes and checks each event word.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Bases for the letter alphabets used as keys and headers.
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam int DRAIN_CYCLES = 12;
    localparam int SEGMENT_BYTES = 217;

    // Parser phases of the local prediction.
    typedef enum logic [2:0] {S_IDLE, S_OPENED, S_HEADER, S_VALUE, S_REKEY} parse_state_t;

    // Table layouts used for the configuration phases.
    typedef enum int {
        TBL_EARLY_MARK, TBL_SATURATED, TBL_NO_RECORDS, TBL_PARTIAL, TBL_RANDOM,
        TBL_ALL_ONES, TBL_DIRECTED
    } table_mode_t;

    // One event word as it leaves the parser.
    typedef struct packed {
        logic [krfp_pkg::KIND_W-1:0] kind;
        logic [krfp_pkg::REC_W-1:0]  rec;
        logic [krfp_pkg::FLD_W-1:0]  fld;
        logic [krfp_pkg::OUT_VW-1:0] val;
    } event_word_t;

    logic clk;
    logic rst_n;

    krfp_rx_if  rx_ch();
    krfp_evt_if evt_ch();
    krfp_cfg_if cfg_ch();

    keyed_record_frame_parser_top u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .evt   (evt_ch),
        .cfg   (cfg_ch)
    );

    // Bytes waiting to be sent and events predicted but not yet seen.
    logic [7:0]  stream_bytes [$];
    event_word_t predicted_events [$];
    event_word_t want;
    int          errors = 0;
    int          bytes_queued = 0;
    int          send_gap_pct = 32;
    int          take_gap_pct = 59;
    logic        rx_taken;

    // Register values as seen by the parser, updated when a write is taken.
    logic [krfp_pkg::RC_W-1:0]   cnt_reg;
    logic [krfp_pkg::KEY_W-1:0]  key_reg;
    logic [krfp_pkg::HDR_W-1:0]  hdr_reg;
    logic [krfp_pkg::MARK_W-1:0] mark_reg;

    // Parse state of the prediction.
    parse_state_t m_state;
    int           m_rec;
    int           m_fld;
    logic [31:0]  m_acc;
    logic [7:0]   m_key;

    // Register values planned by the stimulus for the current phase.
    logic [krfp_pkg::RC_W-1:0]   plan_count;
    logic [krfp_pkg::KEY_W-1:0]  plan_keys;
    logic [krfp_pkg::HDR_W-1:0]  plan_hdrs;
    logic [krfp_pkg::MARK_W-1:0] plan_mark;

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("keyed_record_frame_parser_top: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    task automatic clear_parse();
        m_state = S_IDLE;
        m_rec   = 0;
        m_fld   = 0;
        m_acc   = '0;
        m_key   = '0;
    endtask

    task automatic push_kind(input logic [krfp_pkg::KIND_W-1:0] kind);
        event_word_t ev;
        ev      = '0;
        ev.kind = kind;
        predicted_events.push_back(ev);
    endtask

    // Select the next record whose key matches, or close the frame.
    task automatic close_or_select(input int from, input logic [7:0] c);
        int lim;
        int i;
        bit found;
        lim   = (cnt_reg > krfp_pkg::KEY_SLOTS) ? krfp_pkg::KEY_SLOTS : cnt_reg;
        found = 1'b0;
        for (i = from; i < lim; i++)
        begin
            if (!found && key_reg[8*i +: 8] == c)
            begin
                found   = 1'b1;
                m_state = S_HEADER;
                m_rec   = i;
                m_fld   = 0;
                m_key   = c;
            end
        end
        if (!found)
        begin
            clear_parse();
            push_kind((c == krfp_pkg::CH_T) ? krfp_pkg::EV_OK : krfp_pkg::EV_NO_T);
        end
    endtask

    task automatic header_step(input logic [7:0] c);
        int j;
        bit found;
        bit exhausted;
        found     = 1'b0;
        exhausted = (m_fld >= krfp_pkg::HDR_SLOTS);
        if (!exhausted)
            exhausted = (hdr_reg[8*m_fld +: 8] == mark_reg);
        if (exhausted)
            close_or_select(m_rec + 1, c);
        else if (c == krfp_pkg::CH_Y)
        begin
            clear_parse();
            push_kind(krfp_pkg::EV_ABORT);
        end
        else
        begin
            // Search the remaining headers up to the end marker.
            for (j = m_fld; j < krfp_pkg::HDR_SLOTS; j++)
            begin
                if (hdr_reg[8*j +: 8] == mark_reg)
                    break;
                if (hdr_reg[8*j +: 8] == c)
                begin
                    found   = 1'b1;
                    m_state = S_VALUE;
                    m_fld   = j;
                    m_acc   = '0;
                    break;
                end
            end
            if (!found)
                close_or_select(m_rec + 1, c);
        end
    endtask

    task automatic value_step(input logic [7:0] c);
        event_word_t ev;
        if (c == krfp_pkg::CH_Y)
        begin
            clear_parse();
            push_kind(krfp_pkg::EV_ABORT);
        end
        else if (c != krfp_pkg::CH_PLUS && c != krfp_pkg::CH_MINUS)
        begin
            // Any other byte counts as a digit, even outside '0'..'9'.
            m_acc = m_acc * 32'd10 + {24'd0, c} - {24'd0, krfp_pkg::CH_ZERO};
        end
        else
        begin
            if (c == krfp_pkg::CH_MINUS)
                m_acc = -m_acc;
            ev.kind = krfp_pkg::EV_FIELD;
            ev.rec  = m_rec[krfp_pkg::REC_W-1:0];
            ev.fld  = m_fld[krfp_pkg::FLD_W-1:0];
            ev.val  = m_acc;
            predicted_events.push_back(ev);
            m_fld   = m_fld + 1;
            m_acc   = '0;
            m_state = S_REKEY;
        end
    endtask

    task automatic parse_byte(input logic [7:0] c);
        if (c == krfp_pkg::CH_Z)
        begin
            clear_parse();
            push_kind(krfp_pkg::EV_REBOOT);
        end
        else if (c == krfp_pkg::CH_N)
            push_kind(krfp_pkg::EV_ECHO);
        else
        begin
            case (m_state)
                S_IDLE:
                begin
                    clear_parse();
                    m_state = S_OPENED;
                    push_kind(krfp_pkg::EV_START);
                end
                S_OPENED:
                begin
                    if (c == krfp_pkg::CH_Y)
                    begin
                        clear_parse();
                        push_kind(krfp_pkg::EV_ABORT);
                    end
                    else
                        close_or_select(0, c);
                end
                S_HEADER: header_step(c);
                S_VALUE:  value_step(c);
                S_REKEY:
                begin
                    if (c == m_key)
                        m_state = S_HEADER;
                    else
                        close_or_select(m_rec + 1, c);
                end
                default: clear_parse();
            endcase
        end
    endtask

    task automatic report_field(input string what, input logic [31:0] e, input logic [31:0] a);
        errors++;
        $display("%0t: %s expected %h got %h", $time, what, e, a);
    endtask

    // ---------------------------------------------------------------
    // Monitor: tracks register writes, predicts on each accepted byte
    // and checks each accepted event word.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            cnt_reg  = '0;
            key_reg  = '0;
            hdr_reg  = '0;
            mark_reg = '0;
            rx_taken <= 1'b0;
        end
        else
        begin
            rx_taken <= rx_ch.valid && rx_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    krfp_pkg::CFG_RECORD_COUNT:
                        cnt_reg  = cfg_ch.data[krfp_pkg::RC_W-1:0];
                    krfp_pkg::CFG_KEY_TABLE:
                        key_reg  = cfg_ch.data[krfp_pkg::KEY_W-1:0];
                    krfp_pkg::CFG_HEADER_TABLE:
                        hdr_reg  = cfg_ch.data[krfp_pkg::HDR_W-1:0];
                    krfp_pkg::CFG_END_MARKER:
                        mark_reg = cfg_ch.data[krfp_pkg::MARK_W-1:0];
                    default:          ;
                endcase
            end
            if (rx_ch.valid && rx_ch.ready)
                parse_byte(rx_ch.rx_byte);
            if (evt_ch.valid && evt_ch.ready)
            begin
                if (predicted_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: event word expected none got kind %0d rec %0d fld %0d val %h",
                             $time, evt_ch.event_kind, evt_ch.record_index,
                             evt_ch.field_index, evt_ch.field_value);
                end
                else
                begin
                    want = predicted_events.pop_front();
                    if (want.kind !== evt_ch.event_kind)
                        report_field("event_kind", want.kind, evt_ch.event_kind);
                    if (want.rec !== evt_ch.record_index)
                        report_field("record_index", want.rec, evt_ch.record_index);
                    if (want.fld !== evt_ch.field_index)
                        report_field("field_index", want.fld, evt_ch.field_index);
                    if (want.val !== evt_ch.field_value)
                        report_field("field_value", want.val, evt_ch.field_value);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Driver: sends queued bytes with random gaps and stalls results.
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rx_ch.valid || rx_taken)
        begin
            if (stream_bytes.size() > 0 && $urandom_range(99) >= send_gap_pct)
            begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= stream_bytes.pop_front();
            end
            else
                rx_ch.valid <= 1'b0;
        end
        evt_ch.ready <= ($urandom_range(99) >= take_gap_pct);
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    task automatic write_reg(input logic [krfp_pkg::CFG_IW-1:0] idx,
                             input logic [krfp_pkg::CFG_DW-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Distinct lowercase keys and distinct uppercase headers from A to M.
    task automatic make_letter_tables();
        int i;
        int k;
        bit dup;
        logic [7:0] b;
        for (i = 0; i < krfp_pkg::KEY_SLOTS; i++)
        begin
            do
            begin
                b   = LOWER_A + 8'($urandom_range(25));
                dup = 1'b0;
                for (k = 0; k < i; k++)
                    if (plan_keys[8*k +: 8] == b)
                        dup = 1'b1;
            end while (dup);
            plan_keys[8*i +: 8] = b;
        end
        for (i = 0; i < krfp_pkg::HDR_SLOTS; i++)
        begin
            do
            begin
                b   = UPPER_A + 8'($urandom_range(12));
                dup = 1'b0;
                for (k = 0; k < i; k++)
                    if (plan_hdrs[8*k +: 8] == b)
                        dup = 1'b1;
            end while (dup);
            plan_hdrs[8*i +: 8] = b;
        end
    endtask

    task automatic configure(input table_mode_t mode);
        make_letter_tables();
        case (mode)
            TBL_EARLY_MARK:
            begin
                plan_count = 4'd8;
                plan_mark  = plan_hdrs[16 +: 8];
            end
            TBL_SATURATED:
            begin
                plan_count = 4'd15;
                plan_mark  = 8'h00;
            end
            TBL_NO_RECORDS:
            begin
                plan_count = 4'd0;
                plan_mark  = 8'hFF;
            end
            TBL_PARTIAL:
            begin
                plan_count = 4'($urandom_range(7, 1));
                plan_mark  = plan_hdrs[8*$urandom_range(4) +: 8];
            end
            TBL_RANDOM:
            begin
                plan_count = 4'($urandom_range(15));
                plan_keys  = {$urandom, $urandom};
                plan_hdrs  = {8'($urandom), $urandom};
                plan_mark  = 8'($urandom_range(255));
            end
            TBL_ALL_ONES:
            begin
                plan_count = 4'd8;
                plan_keys  = '1;
                plan_hdrs  = '1;
                plan_mark  = 8'h00;
            end
            default:
            begin
                plan_count = 4'd3;
                plan_keys  = "hgfedcba";
                plan_hdrs  = "EDCBA";
                plan_mark  = 8'hFF;
            end
        endcase
        write_reg(krfp_pkg::CFG_RECORD_COUNT, krfp_pkg::CFG_DW'(plan_count));
        write_reg(krfp_pkg::CFG_KEY_TABLE, krfp_pkg::CFG_DW'(plan_keys));
        write_reg(krfp_pkg::CFG_HEADER_TABLE, krfp_pkg::CFG_DW'(plan_hdrs));
        write_reg(krfp_pkg::CFG_END_MARKER, krfp_pkg::CFG_DW'(plan_mark));
    endtask

    // Queue a byte, now and then preceded by an echo request.
    task automatic queue_byte(input logic [7:0] b);
        if ($urandom_range(99) < 3)
        begin
            stream_bytes.push_back(krfp_pkg::CH_N);
            bytes_queued++;
        end
        stream_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Digits of a value, rarely a stray byte, then the sign terminator.
    task automatic queue_value();
        int n;
        int k;
        logic [7:0] b;
        n = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(6);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(19) == 0)
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == krfp_pkg::CH_Y || b == krfp_pkg::CH_Z ||
                       b == krfp_pkg::CH_PLUS || b == krfp_pkg::CH_MINUS);
            end
            else
                b = krfp_pkg::CH_ZERO + 8'($urandom_range(9));
            queue_byte(b);
        end
        queue_byte($urandom_range(1) ? krfp_pkg::CH_PLUS : krfp_pkg::CH_MINUS);
    endtask

    // A frame that follows the key and header order of the planned tables.
    task automatic queue_frame();
        int lim;
        int i;
        int j;
        bit no_field_yet;
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == krfp_pkg::CH_Z || b == krfp_pkg::CH_N);
        queue_byte(b);
        lim = (plan_count > krfp_pkg::KEY_SLOTS) ? krfp_pkg::KEY_SLOTS : plan_count;
        for (i = 0; i < lim; i++)
        begin
            if ($urandom_range(99) < 60)
            begin
                queue_byte(plan_keys[8*i +: 8]);
                no_field_yet = 1'b1;
                for (j = 0; j < krfp_pkg::HDR_SLOTS; j++)
                begin
                    if (plan_hdrs[8*j +: 8] == plan_mark)
                        break;
                    if ($urandom_range(1))
                    begin
                        if (!no_field_yet)
                            queue_byte(plan_keys[8*i +: 8]);
                        queue_byte(plan_hdrs[8*j +: 8]);
                        queue_value();
                        no_field_yet = 1'b0;
                    end
                end
                // A frame cut short by an abort or a reboot.
                if ($urandom_range(49) == 0)
                begin
                    queue_byte($urandom_range(1) ? krfp_pkg::CH_Y : krfp_pkg::CH_Z);
                    return;
                end
            end
        end
        if ($urandom_range(99) < 70)
            queue_byte(krfp_pkg::CH_T);
        else
            queue_byte(8'($urandom_range(255)));
    endtask

    task automatic queue_noise();
        int n;
        int k;
        n = $urandom_range(6, 1);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(7))
                0:       queue_byte(krfp_pkg::CH_Y);
                1:       queue_byte(krfp_pkg::CH_Z);
                2:       queue_byte(krfp_pkg::CH_N);
                3:       queue_byte(krfp_pkg::CH_T);
                4:       queue_byte(krfp_pkg::CH_PLUS);
                5:       queue_byte(krfp_pkg::CH_MINUS);
                default: queue_byte(8'($urandom_range(255)));
            endcase
        end
    endtask

    // Wait until every byte is sent and every event has come back.
    task automatic wait_idle();
        while (stream_bytes.size() != 0 || rx_ch.valid || predicted_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] opening_bytes [$];
        int seg;

        clk           = 1'b0;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        evt_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: echo, skipped record, stray byte as digit, negative value,
        // header list exhausted, abort in a value, abort after the opener, reboot,
        // 'T' as opener and as closer, unknown key, empty value, 'Y' after a value as closer.
        configure(TBL_DIRECTED);
        opening_bytes = '{8'h00, krfp_pkg::CH_N, "b", "E", 8'hFF, krfp_pkg::CH_MINUS,
                          "b", "c", "A", "9", krfp_pkg::CH_Y, 8'hFF, krfp_pkg::CH_Y,
                          krfp_pkg::CH_Z, krfp_pkg::CH_T, krfp_pkg::CH_T, "A", "a", "Q",
                          "x", "a", "C", krfp_pkg::CH_PLUS, krfp_pkg::CH_Y};
        foreach (opening_bytes[i])
            stream_bytes.push_back(opening_bytes[i]);
        wait_idle();

        // Random frames and noise over several table layouts and gap patterns.
        for (seg = 0; seg < 6; seg++)
        begin
            send_gap_pct = (seg < 2) ? 32 : (seg < 4) ? 59 : 0;
            take_gap_pct = (seg < 2) ? 59 : (seg < 4) ? 32 : 0;
            configure(table_mode_t'(seg));
            bytes_queued = 0;
            while (bytes_queued < SEGMENT_BYTES)
            begin
                if ($urandom_range(99) < 85)
                    queue_frame();
                else
                    queue_noise();
            end
            wait_idle();
        end

        if (errors == 0)
            $display("keyed_record_frame_parser_top: match");
        else
            $display("keyed_record_frame_parser_top: mismatch");
        $finish;
    end

endmodule
